>>> hw/rtl/crocc_pkg.sv
// Shared widths and defaults for the circular range overlap check.
package crocc_pkg;
    localparam int START_W          = 20;
    localparam int LEN_W            = 21;
    localparam int MARGIN_W         = 20;
    localparam int DEVICE_BYTES_DEF = 1048576;
    // Dividend bits retired by each remainder stage
    localparam int REM_BITS_DEF     = 3;
    // Lanes reduced in parallel: first start, second start, first width, second width
    localparam int LANES            = 4;
endpackage

>>> hw/rtl/crocc_rem_pipe.sv
// Pipelined restoring remainder unit: four dividends reduced modulo a shared ring size.
module crocc_rem_pipe #(
    parameter int DW   = crocc_pkg::LEN_W,
    parameter int NW   = 21,
    parameter int BITS = crocc_pkg::REM_BITS_DEF
) (
    input  logic                                    clk,
    input  logic                                    en,
    input  logic [NW-1:0]                           n_in,
    input  logic [crocc_pkg::LANES-1:0][DW-1:0]     x_in,
    output logic [NW-1:0]                           n_out,
    output logic [crocc_pkg::LANES-1:0][NW-1:0]     rem_out
);
    localparam int STAGES = (DW + BITS - 1) / BITS;

    logic [STAGES-1:0][NW-1:0]                          n_reg;
    logic [STAGES-1:0][crocc_pkg::LANES-1:0][DW-1:0]    x_reg;
    logic [STAGES-1:0][crocc_pkg::LANES-1:0][NW-1:0]    r_reg;
    logic [STAGES-1:0][crocc_pkg::LANES-1:0][NW-1:0]    r_next;

    genvar k;
    generate
        for (k = 0; k < STAGES; k++) begin : g_stage
            logic [NW-1:0]                          n_src;
            logic [crocc_pkg::LANES-1:0][DW-1:0]    x_src;
            logic [crocc_pkg::LANES-1:0][NW-1:0]    r_src;

            if (k == 0) begin : g_first
                assign n_src = n_in;
                assign x_src = x_in;
                assign r_src = '0;
            end else begin : g_rest
                assign n_src = n_reg[k-1];
                assign x_src = x_reg[k-1];
                assign r_src = r_reg[k-1];
            end

            // Shift in one dividend bit per step and subtract the ring size when it fits
            always_comb
            begin
                logic [NW:0] t;
                logic [NW-1:0] r;
                r_next[k] = r_src;
                for (int ln = 0; ln < crocc_pkg::LANES; ln++)
                begin
                    r = r_src[ln];
                    for (int j = 0; j < BITS; j++)
                    begin
                        if (k * BITS + j < DW)
                        begin
                            t = {r, x_src[ln][DW - 1 - (k * BITS + j)]};
                            if (t >= {1'b0, n_src})
                            begin
                                t = t - {1'b0, n_src};
                            end
                            r = t[NW-1:0];
                        end
                    end
                    r_next[k][ln] = r;
                end
            end

            // Advance the stage
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    n_reg[k] <= n_src;
                    x_reg[k] <= x_src;
                    r_reg[k] <= r_next[k];
                end
            end
        end
    endgenerate

    assign n_out   = n_reg[STAGES-1];
    assign rem_out = r_reg[STAGES-1];
endmodule

>>> hw/rtl/circular_range_overlap_check_unit.sv
// Pipeline: input stage, 7 remainder stages retiring 3 dividend bits each,
// ring-difference stage, compare/output stage.
// Throughput: one span pair per cycle; a stalled output holds the whole pipeline.
// Reset: asynchronous active-low rst_n clears all valid bits and margin_reg to 0.
// The configuration port is always ready.
module circular_range_overlap_check_unit #(
    parameter int DEVICE_BYTES = crocc_pkg::DEVICE_BYTES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [crocc_pkg::MARGIN_W-1:0]  cfg_data,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [crocc_pkg::START_W-1:0]   first_start,
    input  logic [crocc_pkg::LEN_W-1:0]     first_length,
    input  logic [crocc_pkg::START_W-1:0]   second_start,
    input  logic [crocc_pkg::LEN_W-1:0]     second_length,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic                            spans_overlap,
    output logic                            start_below_margin
);
    localparam int NW     = $clog2(DEVICE_BYTES + 1);
    localparam int DW     = crocc_pkg::LEN_W;
    localparam int BITS   = crocc_pkg::REM_BITS_DEF;
    localparam int STAGES = (DW + BITS - 1) / BITS;
    localparam int MW     = ((NW > crocc_pkg::MARGIN_W) ? NW : crocc_pkg::MARGIN_W) + 1;

    logic [crocc_pkg::MARGIN_W-1:0] margin_reg;
    logic en;

    // Configuration register
    assign cfg_ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            margin_reg <= '0;
        end
        else if (cfg_valid)
        begin
            margin_reg <= cfg_data;
        end
    end

    // Whole pipeline advances unless the output holds an untaken result
    assign en       = !out_valid || out_ready;
    assign in_ready = en;

    // Input stage: margin checks, ring size, shifted starts
    logic [MW-1:0]                 margin_ext;
    logic [MW-1:0]                 n_wide;
    logic                          ring_ok;
    logic                          below;
    logic [NW-1:0]                 n_next;
    logic [crocc_pkg::START_W-1:0] sa, sc;

    assign margin_ext = MW'(margin_reg);
    assign ring_ok    = margin_ext < MW'(DEVICE_BYTES);
    assign n_wide     = MW'(DEVICE_BYTES) - margin_ext;
    assign n_next     = ring_ok ? n_wide[NW-1:0] : NW'(1);
    assign below      = (first_start < margin_reg) || (second_start < margin_reg);
    assign sa         = first_start - margin_reg;
    assign sc         = second_start - margin_reg;

    logic                                v0_reg, below0_reg, ok0_reg;
    logic [NW-1:0]                       n0_reg;
    logic [crocc_pkg::LANES-1:0][DW-1:0] x0_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
        end
        else if (en)
        begin
            v0_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            below0_reg <= below;
            ok0_reg    <= ring_ok;
            n0_reg     <= n_next;
            x0_reg[0]  <= DW'(sa);
            x0_reg[1]  <= DW'(sc);
            x0_reg[2]  <= first_length;
            x0_reg[3]  <= second_length;
        end
    end

    // Remainder stages
    logic [NW-1:0]                       n_r;
    logic [crocc_pkg::LANES-1:0][NW-1:0] rem;

    crocc_rem_pipe #(
        .DW   (DW),
        .NW   (NW),
        .BITS (BITS)
    ) u_rem (
        .clk     (clk),
        .en      (en),
        .n_in    (n0_reg),
        .x_in    (x0_reg),
        .n_out   (n_r),
        .rem_out (rem)
    );

    // Carry valid and flags alongside the remainder stages
    logic [STAGES-1:0] vr_reg, belowr_reg, okr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vr_reg <= '0;
        end
        else if (en)
        begin
            vr_reg <= {vr_reg[STAGES-2:0], v0_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            belowr_reg <= {belowr_reg[STAGES-2:0], below0_reg};
            okr_reg    <= {okr_reg[STAGES-2:0], ok0_reg};
        end
    end

    // Ring difference stage
    logic [NW:0]   dca_wide, dac_wide;
    logic [NW-1:0] a, c;
    assign a        = rem[0];
    assign c        = rem[1];
    assign dca_wide = (c >= a) ? ({1'b0, c} - {1'b0, a}) : ({1'b0, c} + {1'b0, n_r} - {1'b0, a});
    assign dac_wide = (a >= c) ? ({1'b0, a} - {1'b0, c}) : ({1'b0, a} + {1'b0, n_r} - {1'b0, c});

    logic          vd_reg, belowd_reg, okd_reg;
    logic [NW-1:0] dca_reg, dac_reg, w0_reg, w1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vd_reg <= 1'b0;
        end
        else if (en)
        begin
            vd_reg <= vr_reg[STAGES-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            belowd_reg <= belowr_reg[STAGES-1];
            okd_reg    <= okr_reg[STAGES-1];
            dca_reg    <= dca_wide[NW-1:0];
            dac_reg    <= dac_wide[NW-1:0];
            w0_reg     <= rem[2];
            w1_reg     <= rem[3];
        end
    end

    // Compare and output stage
    logic hit;
    assign hit = ((w1_reg != '0) && (dca_reg < w0_reg)) ||
                 ((w0_reg != '0) && (dac_reg < w1_reg));

    logic out_valid_reg, overlap_reg, below_out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= vd_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            overlap_reg   <= hit && okd_reg && !belowd_reg;
            below_out_reg <= belowd_reg;
        end
    end

    assign out_valid          = out_valid_reg;
    assign spans_overlap      = overlap_reg;
    assign start_below_margin = below_out_reg;

    // A start inside the margin never reports an overlap
    a_below_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && start_below_margin) |-> !spans_overlap)
        else $error("overlap reported with start below margin");

    // An empty ring never reports an overlap
    a_empty_ring: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !(margin_ext < MW'(DEVICE_BYTES))) |-> !spans_overlap)
        else $error("overlap reported on empty ring");

    // With no result pending the pipeline must take input
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output");
endmodule
